[rtl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// shared widths and types for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int WIDTH   = 32;
    localparam int CNT_W   = $clog2(WIDTH + 1);
    localparam int NCELLS  = WIDTH;

    // one step of the shift-add-reduce chain
    typedef struct packed {
        logic [WIDTH:0]   acc;    // partial remainder, kept below the modulus
    } mexp_link_t;

endpackage

[rtl/mexp_cell.sv]
// ----------------------------------------------------------------------------
// mexp_cell
// one interleaved modular multiply step: acc = (2*acc + bit*a) mod m
// ----------------------------------------------------------------------------
module mexp_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        mul_bit,
    input  logic [mexp_pkg::WIDTH-1:0]  a_value,
    input  logic [mexp_pkg::WIDTH-1:0]  m_value,
    input  mexp_pkg::mexp_link_t        link_in,
    output mexp_pkg::mexp_link_t        link_out
);

    logic [mexp_pkg::WIDTH+1:0] dbl;
    logic [mexp_pkg::WIDTH+1:0] d1;
    logic [mexp_pkg::WIDTH+1:0] sum;
    logic [mexp_pkg::WIDTH+1:0] mx;
    mexp_pkg::mexp_link_t       link_reg;
    mexp_pkg::mexp_link_t       link_next;

    always_comb
    begin
        mx  = {2'b00, m_value};
        dbl = {link_in.acc, 1'b0};
        d1  = (dbl >= mx) ? dbl - mx : dbl;
        sum = d1 + (mul_bit ? {2'b00, a_value} : '0);
        if (sum >= mx)
        begin
            sum = sum - mx;
        end
        link_next.acc = sum[mexp_pkg::WIDTH:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else if (en)
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

[rtl/mexp_mulmod.sv]
// ----------------------------------------------------------------------------
// mexp_mulmod
// modular multiplier built as a row of cells, one multiplier bit per cell
// ----------------------------------------------------------------------------
module mexp_mulmod
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mexp_pkg::WIDTH-1:0]  a_value,
    input  logic [mexp_pkg::WIDTH-1:0]  b_value,
    input  logic [mexp_pkg::WIDTH-1:0]  m_value,
    output logic                        done,
    output logic [mexp_pkg::WIDTH-1:0]  product
);

    // the token walks down the row; cell i consumes bit WIDTH-1-i of b
    logic [mexp_pkg::NCELLS-1:0]     tok_reg;
    mexp_pkg::mexp_link_t            links [mexp_pkg::NCELLS+1];

    assign links[0].acc = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= {tok_reg[mexp_pkg::NCELLS-2:0], start};
        end
    end

    for (genvar i = 0; i < mexp_pkg::NCELLS; i++)
    begin : g_cell
        mexp_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (i == 0 ? start : tok_reg[(i == 0) ? 0 : i-1]),
            .mul_bit  (b_value[mexp_pkg::WIDTH-1-i]),
            .a_value  (a_value),
            .m_value  (m_value),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    assign done    = tok_reg[mexp_pkg::NCELLS-1];
    assign product = links[mexp_pkg::NCELLS].acc[mexp_pkg::WIDTH-1:0];

endmodule

[rtl/modular_exponentiation_top.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// One request at a time. A modular product runs down a row of WIDTH cells, one
// multiplier bit per cell and clock; the done of one product starts the next
// through the start register. The base is first reduced as the product of one
// and the base, then each exponent bit up to the highest set one costs a
// multiply when the bit is set and a squaring. The exponent's bit length and
// number of set bits set how many products a request takes. Zero and one
// moduli give a valid result the cycle after the request is taken. The result
// sits in an output register; the next request is taken the cycle after that
// one is gone.
module modular_exponentiation_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // base_value, exponent_value, modulus_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // power_result
    output logic        m_tuser    // modulus_error
);

    typedef enum logic [2:0] {IDLE, RED, SQR, MUL, DONE} state_t;

    state_t                       state_reg;
    logic [mexp_pkg::WIDTH-1:0]   run_reg, acc_reg, exp_reg, mod_reg;
    logic [mexp_pkg::CNT_W-1:0]   bit_reg;
    logic                         start_reg;
    logic [mexp_pkg::WIDTH-1:0]   opa, opb;
    logic                         mm_done;
    logic [mexp_pkg::WIDTH-1:0]   mm_prod;
    logic [mexp_pkg::WIDTH-1:0]   in_base, in_exp, in_mod;

    assign in_base = s_tdata[mexp_pkg::WIDTH-1:0];
    assign in_exp  = s_tdata[32 +: mexp_pkg::WIDTH];
    assign in_mod  = s_tdata[64 +: mexp_pkg::WIDTH];

    assign s_tready = (state_reg == IDLE) && !m_tvalid;

    always_comb
    begin
        case (state_reg)
            // one times the base walks the base bits, so any base reduces fully
            RED:     begin opa = mexp_pkg::WIDTH'(1); opb = run_reg; end
            SQR:     begin opa = run_reg; opb = run_reg; end
            MUL:     begin opa = acc_reg; opb = run_reg; end
            default: begin opa = run_reg; opb = run_reg; end
        endcase
    end

    mexp_mulmod u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .a_value (opa),
        .b_value (opb),
        .m_value (mod_reg),
        .done    (mm_done),
        .product (mm_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            start_reg <= 1'b0;
            m_tvalid  <= 1'b0;
            m_tdata   <= '0;
            m_tuser   <= 1'b0;
            bit_reg   <= '0;
            run_reg   <= '0;
            acc_reg   <= '0;
            exp_reg   <= '0;
            mod_reg   <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        run_reg <= in_base;
                        exp_reg <= in_exp;
                        mod_reg <= in_mod;
                        acc_reg <= mexp_pkg::WIDTH'(1);
                        bit_reg <= '0;
                        if (in_mod <= mexp_pkg::WIDTH'(1))
                        begin
                            m_tvalid  <= 1'b1;
                            m_tdata   <= '0;
                            m_tuser   <= (in_mod == '0);
                            start_reg <= 1'b0;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            state_reg <= RED;
                        end
                    end
                    else
                    begin
                        start_reg <= 1'b0;
                    end
                end
                RED:
                begin
                    if (mm_done)
                    begin
                        run_reg <= mm_prod;
                        if (exp_reg == '0)
                        begin
                            start_reg <= 1'b0;
                            state_reg <= DONE;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            state_reg <= exp_reg[0] ? MUL : SQR;
                        end
                    end
                    else
                    begin
                        start_reg <= 1'b0;
                    end
                end
                SQR:
                begin
                    if (mm_done)
                    begin
                        run_reg <= mm_prod;
                        exp_reg <= exp_reg >> 1;
                        bit_reg <= bit_reg + 1'b1;
                        if (bit_reg == mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1)
                            || (exp_reg >> 1) == '0)
                        begin
                            start_reg <= 1'b0;
                            state_reg <= DONE;
                        end
                        else
                        begin
                            // next exponent bit picks multiply or another square
                            start_reg <= 1'b1;
                            state_reg <= exp_reg[1] ? MUL : SQR;
                        end
                    end
                    else
                    begin
                        start_reg <= 1'b0;
                    end
                end
                MUL:
                begin
                    if (mm_done)
                    begin
                        acc_reg   <= mm_prod;
                        start_reg <= 1'b1;
                        state_reg <= SQR;
                    end
                    else
                    begin
                        start_reg <= 1'b0;
                    end
                end
                DONE:
                begin
                    start_reg <= 1'b0;
                    if (!m_tvalid)
                    begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= 32'(acc_reg);
                        m_tuser   <= 1'b0;
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    start_reg <= 1'b0;
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for modular_exponentiation_top: random and corner-case
// requests, predicted results compared in order against the result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class power_scoreboard;
    logic [31:0] power_q[$];
    logic        error_q[$];
    int          mismatches;

    function automatic logic [31:0] power_mod(logic [31:0] b, logic [31:0] e,
                                              logic [31:0] m);
        logic [63:0] acc;
        logic [63:0] run;
        acc = 64'd1;
        run = 64'(b % m);
        for (int i = 0; i < 32; i++)
        begin
            if (e[i])
                acc = (acc * run) % m;
            run = (run * run) % m;
        end
        return acc[31:0];
    endfunction

    function void note_request(logic [31:0] b, logic [31:0] e, logic [31:0] m);
        if (m == 0)
        begin
            power_q.push_back(32'd0);
            error_q.push_back(1'b1);
        end
        else if (m == 1)
        begin
            power_q.push_back(32'd0);
            error_q.push_back(1'b0);
        end
        else
        begin
            power_q.push_back(power_mod(b, e, m));
            error_q.push_back(1'b0);
        end
    endfunction

    function void check_result(logic [31:0] p, logic err);
        logic [31:0] ep;
        logic        ee;
        if (power_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result power=%h err=%b", p, err);
            return;
        end
        ep = power_q.pop_front();
        ee = error_q.pop_front();
        if (ep !== p || ee !== err)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected power=%h err=%b, got power=%h err=%b",
                         ep, ee, p, err);
        end
    endfunction

    function int pending();
        return power_q.size();
    endfunction
endclass

module tb;
    localparam int TIMEOUT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    power_scoreboard sb;
    int  idle_cycles;
    bit  hold_off;
    bit  stim_done;

    modular_exponentiation_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 3);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2:       return $urandom_range(0, 255);
            3:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(logic [31:0] b, logic [31:0] e, logic [31:0] m);
        s_tvalid <= 1'b1;
        s_tdata  <= {m, e, b};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(b, e, m);
    endtask

    task automatic gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > TIMEOUT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        int burst;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cases: zero and one moduli, zero exponent, field extremes
        send_request(32'd5, 32'd3, 32'd0);
        send_request(32'd0, 32'd0, 32'd0);
        send_request(32'd7, 32'd0, 32'd1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send_request(32'd9, 32'd0, 32'd13);
        send_request(32'd0, 32'd0, 32'd2);
        send_request(32'd0, 32'd5, 32'd11);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
        send_request(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE);
        send_request(32'd123, 32'd65537, 32'd3233);
        send_request(32'd855, 32'd2753, 32'd3233);
        send_request(32'd2, 32'd31, 32'h8000_0000);
        send_request(32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'd3, 32'd1, 32'd2);
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (4)
                    send_request($urandom, $urandom, $urandom_range(0, 1000));
            end
        join
        wait_drained();

        for (int n = 0; n < 275; )
        begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && n < 275; k++, n++)
            begin
                // moduli of zero or one send about one request in ten down the fast path too
                if ($urandom_range(0, 9) == 0)
                    send_request(rand_operand(), rand_operand(), $urandom_range(0, 1));
                else
                    send_request(rand_operand(), rand_operand(), rand_operand());
            end
            if ($urandom_range(0, 2) != 0)
                gap($urandom_range(1, 40));
            if (n == 140)
                wait_drained();
        end
        wait_drained();
        repeat (50) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
